>>> hw/rtl/utf8d_pkg.sv
// shared constants, types and lead byte classing for the utf-8 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  // longest sequence that is decoded, 4 to 6
  localparam int MAX_SEQUENCE_BYTES = 6;

  localparam int BYTE_W    = 8;
  localparam int CP_W      = 31;
  localparam int CNT_W     = 3;
  localparam int HELD_W    = MAX_SEQUENCE_BYTES * BYTE_W;
  localparam int OUT_DATA_W = ((CP_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - CP_W - CNT_W;

  // prefix masks and patterns of lead bytes
  localparam logic [7:0] MASK_2 = 8'hE0;
  localparam logic [7:0] PAT_2  = 8'hC0;
  localparam logic [7:0] MASK_3 = 8'hF0;
  localparam logic [7:0] PAT_3  = 8'hE0;
  localparam logic [7:0] MASK_4 = 8'hF8;
  localparam logic [7:0] PAT_4  = 8'hF0;
  localparam logic [7:0] MASK_5 = 8'hFC;
  localparam logic [7:0] PAT_5  = 8'hF8;
  localparam logic [7:0] MASK_6 = 8'hFE;
  localparam logic [7:0] PAT_6  = 8'hFC;
  localparam logic [7:0] LEAD_PAYLOAD = 8'h7F;
  localparam logic [7:0] CONT_PAYLOAD = 8'h3F;

  // commands from the controller to the datapath
  typedef struct packed {
    logic flushing;
    logic start_seq;
    logic append;
    logic shift;
    logic clear_seq;
    logic load_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic seq_open;
    logic seq_done;
    logic lead_multi;
    logic piece_last;
  } sts_t;

  // sequence length implied by a lead byte, one for anything else
  function automatic logic [CNT_W-1:0] lead_class(input logic [7:0] b);
    logic [CNT_W-1:0] n;
    n = CNT_W'(1);
    if ((b & MASK_2) == PAT_2)      n = CNT_W'(2);
    else if ((b & MASK_3) == PAT_3) n = CNT_W'(3);
    else if ((b & MASK_4) == PAT_4) n = CNT_W'(4);
    else if ((b & MASK_5) == PAT_5) n = CNT_W'(5);
    else if ((b & MASK_6) == PAT_6) n = CNT_W'(6);
    if (n > CNT_W'(MAX_SEQUENCE_BYTES)) n = CNT_W'(1);
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utf8d_datapath.sv
// held byte buffer, single character decoder and output register
`timescale 1ns / 1ps
`default_nettype none

module utf8d_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [7:0]                in_data,
  input  wire utf8d_pkg::cmd_t           cmd,
  output utf8d_pkg::sts_t                sts,
  output logic [utf8d_pkg::CP_W-1:0]     out_cp,
  output logic [utf8d_pkg::CNT_W-1:0]    out_len,
  output logic                           out_last
);

  logic [utf8d_pkg::HELD_W-1:0] held_r, held_nxt;
  logic [utf8d_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [utf8d_pkg::CNT_W-1:0]  exp_r, exp_nxt;
  logic [utf8d_pkg::CP_W-1:0]   out_cp_r;
  logic [utf8d_pkg::CNT_W-1:0]  out_len_r;
  logic                         out_last_r;

  logic [7:0]                   win [utf8d_pkg::MAX_SEQUENCE_BYTES];
  logic [utf8d_pkg::CNT_W-1:0]  avail;
  logic [utf8d_pkg::CNT_W-1:0]  lead_n;
  logic                         raw;
  logic [utf8d_pkg::CNT_W-1:0]  dec_len;
  logic [utf8d_pkg::CP_W-1:0]   dec_cp;
  logic [utf8d_pkg::CNT_W:0]    total;

  // decode window: held bytes, with the incoming byte after them when accepting
  always_comb begin
    for (int i = 0; i < utf8d_pkg::MAX_SEQUENCE_BYTES; i++) begin
      if (cmd.flushing || (utf8d_pkg::CNT_W'(i) < count_r)) begin
        win[i] = held_r[i*8 +: 8];
      end else begin
        win[i] = in_data;
      end
    end
  end

  assign avail = cmd.flushing ? count_r : count_r + utf8d_pkg::CNT_W'(1);

  // one character from the front of the window
  always_comb begin
    lead_n  = utf8d_pkg::lead_class(win[0]);
    raw     = (lead_n < utf8d_pkg::CNT_W'(2)) || (lead_n > avail);
    dec_len = raw ? utf8d_pkg::CNT_W'(1) : lead_n;
    if (raw) begin
      dec_cp = utf8d_pkg::CP_W'(win[0]);
    end else begin
      dec_cp = utf8d_pkg::CP_W'(win[0] & (utf8d_pkg::LEAD_PAYLOAD >> lead_n));
      for (int i = 1; i < utf8d_pkg::MAX_SEQUENCE_BYTES; i++) begin
        if (utf8d_pkg::CNT_W'(i) < lead_n) begin
          dec_cp = {dec_cp[utf8d_pkg::CP_W-7:0], win[i][5:0] & utf8d_pkg::CONT_PAYLOAD[5:0]};
        end
      end
    end
  end

  // status for the controller
  assign total           = {1'b0, count_r} + (utf8d_pkg::CNT_W+1)'(1);
  assign sts.seq_open    = (exp_r != '0);
  assign sts.seq_done    = (total >= {1'b0, exp_r});
  assign sts.lead_multi  = (utf8d_pkg::lead_class(in_data) != utf8d_pkg::CNT_W'(1));
  assign sts.piece_last  = (dec_len == count_r);

  // held sequence update
  always_comb begin
    held_nxt  = held_r;
    count_nxt = count_r;
    exp_nxt   = exp_r;
    if (cmd.start_seq) begin
      held_nxt[7:0] = in_data;
      count_nxt     = utf8d_pkg::CNT_W'(1);
      exp_nxt       = utf8d_pkg::lead_class(in_data);
    end
    if (cmd.append) begin
      for (int i = 0; i < utf8d_pkg::MAX_SEQUENCE_BYTES; i++) begin
        if (utf8d_pkg::CNT_W'(i) == count_r) held_nxt[i*8 +: 8] = in_data;
      end
      count_nxt = count_r + utf8d_pkg::CNT_W'(1);
    end
    if (cmd.shift) begin
      held_nxt  = held_r >> {dec_len, 3'b000};
      count_nxt = count_r - dec_len;
    end
    if (cmd.clear_seq) begin
      count_nxt = '0;
      exp_nxt   = '0;
    end
  end

  // buffer bytes carry no reset
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      exp_r   <= '0;
    end else begin
      count_r <= count_nxt;
      exp_r   <= exp_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cp_r   <= dec_cp;
      out_len_r  <= dec_len;
      out_last_r <= cmd.flushing ? sts.piece_last : 1'b1;
    end
  end

  assign out_cp   = out_cp_r;
  assign out_len  = out_len_r;
  assign out_last = out_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/utf8d_ctrl.sv
// controller: accept and flush sequencing, output word valid
`timescale 1ns / 1ps
`default_nettype none

module utf8d_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_eob,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire utf8d_pkg::sts_t  sts,
  output utf8d_pkg::cmd_t       cmd
);

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_FLUSH  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic in_fire;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_ACCEPT) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.flushing  = (state_r == ST_FLUSH);
    case (state_r)
      ST_ACCEPT: begin
        if (in_fire) begin
          if (!sts.seq_open) begin
            if (sts.lead_multi && !in_eob) cmd.start_seq = 1'b1;
            else                           cmd.load_out  = 1'b1;
          end else if (sts.seq_done) begin
            cmd.load_out  = 1'b1;
            cmd.clear_seq = 1'b1;
          end else begin
            cmd.append = 1'b1;
            if (in_eob) state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          cmd.shift    = 1'b1;
          if (sts.piece_last) begin
            cmd.clear_seq = 1'b1;
            state_nxt     = ST_ACCEPT;
          end
        end
      end
      default: state_nxt = ST_ACCEPT;
    endcase
  end

  // output word valid
  always_comb begin
    if (cmd.load_out)      out_valid_nxt = 1'b1;
    else if (out_tready)   out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_stream_decoder.sv
// top level: legacy utf-8 stream decoder, up to six bytes per character
// a result word is shown the cycle after the byte that completes it
// one byte per cycle while result words are taken and no flush is running
// a buffer that ends inside a sequence flushes up to five words, one per cycle
// while words are taken, as the single decoder walks the held bytes
// reset (rst_n low, synchronous): no open sequence, no output word valid
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  wire logic                              in_tlast,   // end_of_buffer
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [30:0] code_point, [33:31] byte_count, rest zero
  output logic [utf8d_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                   out_tlast   // run_last
);

  utf8d_pkg::cmd_t              cmd;
  utf8d_pkg::sts_t              sts;
  logic [utf8d_pkg::CP_W-1:0]   out_cp;
  logic [utf8d_pkg::CNT_W-1:0]  out_len;

  // sequencing
  utf8d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_eob     (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // buffer and decoder
  utf8d_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_cp   (out_cp),
    .out_len  (out_len),
    .out_last (out_tlast)
  );

  // pack the result word
  assign out_tdata = {{utf8d_pkg::OUT_PAD_W{1'b0}}, out_len, out_cp};

endmodule

`default_nettype wire

>>> hw/rtl/utf8d_checker.sv
// port checker for the utf-8 stream decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module utf8d_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [7:0]                        in_tdata,
  input wire logic                              in_tlast,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [utf8d_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic                              out_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // byte count within one and the longest sequence
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:31] != 3'd0) &&
                   (out_tdata[33:31] <= 3'(utf8d_pkg::MAX_SEQUENCE_BYTES)))
    else $error("byte count out of range");

  // a one byte result carries a byte value
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:31] == 3'd1) |-> (out_tdata[30:8] == '0))
    else $error("single byte result wider than a byte");

  // no byte taken while a word is stalled
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("byte accepted while output word stalled");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[utf8d_pkg::OUT_DATA_W-1:34] == '0))
    else $error("padding bits set");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> sim/utf8_stream_decoder_tb.sv
// self-checking testbench for the utf-8 stream decoder, with its own decode model
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_tb;

  // receiver stall patterns
  localparam int READY_FULL = 0;
  localparam int READY_COIN = 1;
  localparam int READY_DUTY = 2;

  // one decoded character as the block should show it
  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0]  code_point;
    logic [utf8d_pkg::CNT_W-1:0] byte_count;
    logic                        run_last;
  } char_word_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata = 8'h00;    // [7:0] data_byte
  logic                             in_tlast = 1'b0;     // end_of_buffer
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [30:0] code_point, [33:31] byte_count
  logic [utf8d_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             out_tlast;           // run_last

  // decode model state
  logic [7:0] open_bytes [0:utf8d_pkg::MAX_SEQUENCE_BYTES-2];
  int         open_count = 0;
  int         open_len = 0;
  logic [7:0] seq_buf [0:utf8d_pkg::MAX_SEQUENCE_BYTES-1];

  char_word_t pending_chars [$];
  char_word_t seen_char;
  char_word_t want_char;

  int errors = 0;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int flushes_seen = 0;
  int chars_checked = 0;
  int burst_left = 0;
  int gap_max = 0;
  int ready_mode = READY_FULL;
  int cyc = 0;

  utf8_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sequence length from the prefix of a lead byte
  function automatic int seq_class(input logic [7:0] b);
    int n;
    casez (b)
      8'b0???????: n = 1;
      8'b110?????: n = 2;
      8'b1110????: n = 3;
      8'b11110???: n = 4;
      8'b111110??: n = 5;
      8'b1111110?: n = 6;
      default:     n = 1;
    endcase
    if (n > utf8d_pkg::MAX_SEQUENCE_BYTES) n = 1;
    return n;
  endfunction

  // decode one character from seq_buf[p], with avail bytes left
  task automatic decode_at(input int p, input int avail, output logic [31:0] cp,
                           output int len);
    int n;
    n = seq_class(seq_buf[p]);
    if (n < 2 || n > avail) begin
      cp = {24'd0, seq_buf[p]};
      len = 1;
    end else begin
      cp = {24'd0, seq_buf[p] & (8'h7F >> n)};
      for (int i = 1; i < n; i++)
        cp = (cp << 6) | {26'd0, seq_buf[p + i][5:0]};
      len = n;
    end
  endtask

  function automatic char_word_t make_char(input logic [31:0] cp, input int len,
                                           input logic last);
    char_word_t c;
    c.code_point = cp[utf8d_pkg::CP_W-1:0];
    c.byte_count = len[utf8d_pkg::CNT_W-1:0];
    c.run_last = last;
    return c;
  endfunction

  // advance the decode model by one accepted byte, queueing what it emits
  task automatic utf8_decode_byte(input logic [7:0] d, input logic eob);
    int          total;
    int          p;
    int          len;
    logic [31:0] cp;
    if (open_len == 0) begin
      if (seq_class(d) == 1 || eob) begin
        pending_chars.push_back(make_char({24'd0, d}, 1, 1'b1));
      end else begin
        open_bytes[0] = d;
        open_count = 1;
        open_len = seq_class(d);
      end
    end else begin
      for (int i = 0; i < open_count; i++) seq_buf[i] = open_bytes[i];
      seq_buf[open_count] = d;
      total = open_count + 1;
      if (total >= open_len) begin
        decode_at(0, total, cp, len);
        pending_chars.push_back(make_char(cp, len, 1'b1));
        open_count = 0;
        open_len = 0;
      end else if (!eob) begin
        open_bytes[open_count] = d;
        open_count++;
      end else begin
        // truncated: lead goes out raw, the rest is decoded again
        flushes_seen++;
        pending_chars.push_back(make_char({24'd0, seq_buf[0]}, 1, 1'b0));
        p = 1;
        while (p < total) begin
          decode_at(p, total - p, cp, len);
          pending_chars.push_back(make_char(cp, len, p + len >= total));
          p += len;
        end
        open_count = 0;
        open_len = 0;
      end
    end
  endtask

  // send one byte word, with the burst and gap pattern of the sender
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tdata <= b;
    in_tlast <= eob;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    utf8_decode_byte(b, eob);
    bytes_sent++;
    if (eob) buffers_sent++;
    @(negedge clk);
  endtask

  // lead byte of a character of n bytes, random payload
  function automatic logic [7:0] lead_byte(input int n);
    case (n)
      1:       return 8'($urandom_range(0, 127));
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      4:       return 8'hF0 | 8'($urandom_range(0, 7));
      5:       return 8'hF8 | 8'($urandom_range(0, 3));
      default: return 8'hFC | 8'($urandom_range(0, 1));
    endcase
  endfunction

  // character length, mostly short
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 1;
    if (r < 6) return 2;
    if (r < 8) return 3;
    if (r == 8) return 4;
    return $urandom_range(5, 6);
  endfunction

  // one complete character; a few continuation bytes are arbitrary
  task automatic send_char(input int n, input logic eob_last);
    logic [7:0] b;
    send_byte(lead_byte(n), eob_last && n == 1);
    for (int i = 1; i < n; i++) begin
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : (8'h80 | 8'($urandom_range(0, 63)));
      send_byte(b, eob_last && i == n - 1);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    cyc <= cyc + 1;
    case (ready_mode)
      READY_COIN: out_tready <= ($urandom_range(0, 1) == 1);
      READY_DUTY: out_tready <= ((cyc % 7) < 4);
      default:    out_tready <= 1'b1;
    endcase
  end

  // compare each result word with the oldest expected character
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_char.code_point = out_tdata[utf8d_pkg::CP_W-1:0];
      seen_char.byte_count = out_tdata[utf8d_pkg::CP_W +: utf8d_pkg::CNT_W];
      seen_char.run_last = out_tlast;
      if (pending_chars.size() == 0) begin
        $display("%0t: result word with none expected, cp=%h count=%0d last=%b",
                 $time, seen_char.code_point, seen_char.byte_count, seen_char.run_last);
        errors++;
      end else begin
        want_char = pending_chars.pop_front();
        chars_checked++;
        if (seen_char.code_point !== want_char.code_point) begin
          $display("%0t: code_point expected %h got %h", $time,
                   want_char.code_point, seen_char.code_point);
          errors++;
        end
        if (seen_char.byte_count !== want_char.byte_count) begin
          $display("%0t: byte_count expected %0d got %0d", $time,
                   want_char.byte_count, seen_char.byte_count);
          errors++;
        end
        if (seen_char.run_last !== want_char.run_last) begin
          $display("%0t: run_last expected %b got %b", $time,
                   want_char.run_last, seen_char.run_last);
          errors++;
        end
        if ((out_tdata >> (utf8d_pkg::CP_W + utf8d_pkg::CNT_W)) !== '0) begin
          $display("%0t: pad bits expected 0 got %h", $time,
                   out_tdata >> (utf8d_pkg::CP_W + utf8d_pkg::CNT_W));
          errors++;
        end
      end
    end
  end

  // extremes, two, three and six byte leads, truncation and ascii inside a sequence
  task automatic test_directed();
    gap_max = 3;
    ready_mode = READY_COIN;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    // ascii bytes taken as continuations
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    // six bytes, largest code point
    send_byte(8'hFD, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);
    // lead on the last byte of a buffer
    send_byte(8'hC3, 1'b1);
    // buffer ends inside a six byte sequence
    send_byte(8'hFC, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  // buffers of random characters, mostly well-formed, under every stall pattern
  task automatic test_well_formed();
    int nchars;
    for (int bufno = 0; bufno < 16; bufno++) begin
      ready_mode = bufno % 3;
      gap_max = (bufno % 4 == 3) ? 0 : 4;
      nchars = $urandom_range(1, 8);
      for (int c = 0; c < nchars; c++) send_char(pick_len(), c == nchars - 1);
    end
  endtask

  // buffers cut inside a sequence, held bytes of every kind
  task automatic test_truncated();
    int n;
    int k;
    int r;
    logic [7:0] b;
    ready_mode = READY_DUTY;
    gap_max = 5;
    for (int bufno = 0; bufno < 40; bufno++) begin
      if (bufno == 20) ready_mode = READY_COIN;
      repeat ($urandom_range(0, 2)) send_char(pick_len(), 1'b0);
      n = $urandom_range(2, utf8d_pkg::MAX_SEQUENCE_BYTES);
      k = $urandom_range(0, n - 2);
      send_byte(lead_byte(n), k == 0);
      for (int i = 1; i <= k; i++) begin
        r = $urandom_range(0, 2);
        if (r == 0) b = 8'($urandom_range(0, 127));
        else if (r == 1) b = 8'h80 | 8'($urandom_range(0, 63));
        else b = lead_byte($urandom_range(2, 6));
        send_byte(b, i == k);
      end
    end
  endtask

  // arbitrary bytes with an occasional end of buffer
  task automatic test_noise();
    ready_mode = READY_COIN;
    gap_max = 6;
    for (int i = 0; i < 100; i++)
      send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // back to back words with the receiver always ready
  task automatic test_full_rate();
    ready_mode = READY_FULL;
    gap_max = 0;
    for (int c = 0; c < 40; c++) send_char(pick_len(), c % 10 == 9);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_well_formed();
    test_truncated();
    test_noise();
    test_full_rate();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d bytes in %0d buffers, %0d of them cut inside a sequence",
             bytes_sent, buffers_sent, flushes_seen);
    $display("checked %0d decoded characters, %0d mismatches", chars_checked, errors);
    if (errors == 0) begin
      $display("utf8_stream_decoder_tb OK");
    end else begin
      $display("utf8_stream_decoder_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("utf8_stream_decoder_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_datapath.sv
hw/rtl/utf8d_ctrl.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/utf8d_checker.sv
sim/utf8_stream_decoder_tb.sv
